@@ hw/rtl/nns_pkg.sv @@
`default_nettype none
package nns_pkg;

  localparam int COORD_W   = 12;
  localparam int PIX_W     = 32;
  localparam int SIZE_W    = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;
  localparam int PROD_W    = COORD_W + SIZE_W;

  localparam logic [SIZE_W-1:0] DST_LIMIT = 13'd4096;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POW2_MODE  = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0] sw;
    logic [SIZE_W-1:0] sh;
    logic [SIZE_W-1:0] dw;
    logic [SIZE_W-1:0] dh;
  } sizes_t;

  // round up to a power of two; v is at least 1 and at most 1024
  function automatic logic [SIZE_W-1:0] next_pow2(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] m;
    begin
      m = v - SIZE_W'(1);
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      next_pow2 = m + SIZE_W'(1);
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/nns_in_if.sv @@
`default_nettype none
interface nns_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [nns_pkg::COORD_W-1:0] coord_x;
  logic [nns_pkg::COORD_W-1:0] coord_y;
  logic [nns_pkg::PIX_W-1:0]   pixel_in;
  modport source (output valid, cmd, coord_x, coord_y, pixel_in, input ready);
  modport sink (input valid, cmd, coord_x, coord_y, pixel_in, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/nns_out_if.sv @@
`default_nettype none
interface nns_out_if;
  logic                     valid;
  logic                     ready;
  logic [nns_pkg::PIX_W-1:0] pixel_out;
  logic                     range_error;
  modport source (output valid, pixel_out, range_error, input ready);
  modport sink (input valid, pixel_out, range_error, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/nns_cfg_if.sv @@
`default_nettype none
interface nns_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [nns_pkg::CFG_IDX_W-1:0] index;
  logic [nns_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/nns_ram.sv @@
`default_nettype none
module nns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/nns_cfg.sv @@
`default_nettype none
module nns_cfg #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  nns_cfg_if.sink      cfg_ch,
  output nns_pkg::sizes_t sizes
);
  import nns_pkg::*;

  logic [8:0]        src_width_r, src_height_r;
  logic [SIZE_W-1:0] dst_width_r, dst_height_r;
  logic              pow2_mode_r;
  logic [SIZE_W-1:0] sw, sh, dw_lin, dh_lin;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 9'd256;
      src_height_r <= 9'd256;
      dst_width_r  <= 13'd256;
      dst_height_r <= 13'd256;
      pow2_mode_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SRC_WIDTH:  src_width_r  <= cfg_ch.data[8:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_ch.data[8:0];
        REG_DST_WIDTH:  dst_width_r  <= cfg_ch.data;
        REG_DST_HEIGHT: dst_height_r <= cfg_ch.data;
        REG_POW2_MODE:  pow2_mode_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    sw = (src_width_r == 9'd0) ? SIZE_W'(1) :
         ({4'b0, src_width_r} > SIZE_W'(MAX_SRC_WIDTH)) ? SIZE_W'(MAX_SRC_WIDTH) :
         {4'b0, src_width_r};
    sh = (src_height_r == 9'd0) ? SIZE_W'(1) :
         ({4'b0, src_height_r} > SIZE_W'(MAX_SRC_HEIGHT)) ? SIZE_W'(MAX_SRC_HEIGHT) :
         {4'b0, src_height_r};
    dw_lin = (dst_width_r == '0) ? SIZE_W'(1) :
             (dst_width_r > DST_LIMIT) ? DST_LIMIT : dst_width_r;
    dh_lin = (dst_height_r == '0) ? SIZE_W'(1) :
             (dst_height_r > DST_LIMIT) ? DST_LIMIT : dst_height_r;
    sizes.sw = sw;
    sizes.sh = sh;
    sizes.dw = pow2_mode_r ? next_pow2(sw) : dw_lin;
    sizes.dh = pow2_mode_r ? next_pow2(sh) : dh_lin;
  end
endmodule
`default_nettype wire

@@ hw/rtl/nns_div.sv @@
`default_nettype none
module nns_div #(
  parameter int QB = 8
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [nns_pkg::PROD_W-1:0]    num,
  input  wire logic [nns_pkg::SIZE_W-1:0]    den,
  output logic      [QB-1:0]                 quot
);
  import nns_pkg::*;

  localparam int RW = PROD_W + QB + 1;

  logic [RW-1:0] rem_r [QB];
  logic [QB-1:0] q_r   [QB];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] rem_in, dsh;
    logic [QB-1:0] q_in;
    logic          take;
    if (k == 0) begin : g_first
      assign rem_in = RW'(num);
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
    end
    assign dsh  = RW'(den) << (QB - 1 - k);
    assign take = (rem_in >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? (rem_in - dsh) : rem_in;
        q_r[k]   <= q_in | (take ? (QB'(1) << (QB - 1 - k)) : '0);
      end
    end
  end

  assign quot = q_r[QB-1];
endmodule
`default_nettype wire

@@ hw/rtl/nearest_neighbor_image_scaler_unit.sv @@
`default_nettype none
// Nearest-neighbor scaler over one stored RGBA source frame.
// in_ch carries words of cmd, coord_x, coord_y, pixel_in. A write word stores
// pixel_in at source (coord_x, coord_y) and gives no result; writes outside the
// source size are dropped. A read word gives one out_ch word holding the source
// pixel at (x*W/DW, y*H/DH), or zero with range_error set when (x, y) lies
// outside the destination size.
// cfg_ch writes the size registers by index; it is always ready and must only
// be used while no read is in flight.
// Throughput is one word per cycle while out_ch does not stall. A read result
// passes the multiply stage, which loads at acceptance, then a pipelined
// restoring divider with one quotient bit per stage, then one frame store read.
// Words leave in the order they were accepted.
// When out_ch stalls with a result pending the whole pipeline holds and in_ch
// ready drops. Reset clears the pipeline and loads the default sizes; the frame
// store is not cleared and must be written before it is read.
module nearest_neighbor_image_scaler_unit #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  nns_in_if.sink    in_ch,
  nns_out_if.source out_ch,
  nns_cfg_if.sink   cfg_ch
);
  import nns_pkg::*;

  localparam int XW    = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int YW    = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
  localparam int QB    = (XW > YW) ? XW : YW;
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic             valid;
    logic             cmd;
    logic             err;
    logic             wr_ok;
    logic [QB-1:0]    wx;
    logic [QB-1:0]    wy;
    logic [PIX_W-1:0] pix;
  } side_t;

  sizes_t          sizes;
  logic            adv;
  side_t           side_a_nxt;
  side_t           side_r [QB+1];
  logic [PROD_W-1:0] prod_x_r, prod_y_r;
  logic [QB-1:0]   qx, qy, col, row;
  logic [AW-1:0]   addr;
  logic            out_valid_r, out_err_r;
  logic [PIX_W-1:0] ram_q;

  nns_cfg #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)) u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .sizes(sizes)
  );

  // hold everything while a result waits
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    side_a_nxt.valid = in_ch.valid;
    side_a_nxt.cmd   = in_ch.cmd;
    side_a_nxt.err   = ({1'b0, in_ch.coord_x} >= sizes.dw) ||
                       ({1'b0, in_ch.coord_y} >= sizes.dh);
    side_a_nxt.wr_ok = ({1'b0, in_ch.coord_x} < sizes.sw) &&
                       ({1'b0, in_ch.coord_y} < sizes.sh);
    side_a_nxt.wx    = in_ch.coord_x[QB-1:0];
    side_a_nxt.wy    = in_ch.coord_y[QB-1:0];
    side_a_nxt.pix   = in_ch.pixel_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) begin
        side_r[i].valid <= 1'b0;
      end
    end else if (adv) begin
      side_r[0] <= side_a_nxt;
      prod_x_r  <= PROD_W'(in_ch.coord_x) * PROD_W'(sizes.sw);
      prod_y_r  <= PROD_W'(in_ch.coord_y) * PROD_W'(sizes.sh);
      for (int i = 1; i <= QB; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  nns_div #(.QB(QB)) u_div_x (
    .clk(clk), .en(adv), .num(prod_x_r), .den(sizes.dw), .quot(qx)
  );
  nns_div #(.QB(QB)) u_div_y (
    .clk(clk), .en(adv), .num(prod_y_r), .den(sizes.dh), .quot(qy)
  );

  // writes and reads hit the store in acceptance order at the same stage
  assign col  = (side_r[QB].cmd == CMD_READ) ? qx : side_r[QB].wx;
  assign row  = (side_r[QB].cmd == CMD_READ) ? qy : side_r[QB].wy;
  assign addr = AW'(row) * AW'(MAX_SRC_WIDTH) + AW'(col);

  nns_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
    .clk(clk),
    .we(adv && side_r[QB].valid && (side_r[QB].cmd == CMD_WRITE) && side_r[QB].wr_ok),
    .waddr(addr),
    .wdata(side_r[QB].pix),
    .re(adv),
    .raddr(addr),
    .rdata_r(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= side_r[QB].valid && (side_r[QB].cmd == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_err_r <= side_r[QB].err;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.range_error = out_err_r;
  assign out_ch.pixel_out   = out_err_r ? '0 : ram_q;
endmodule
`default_nettype wire
